@@ hw/rtl/ssdiv_pkg.sv @@
// ============================================================================
// ssdiv_pkg: shared types and constants for the signed shift-subtract divider
// Holds the operand width, derived port widths and the sequencer state type.
// ============================================================================
`default_nettype none

package ssdiv_pkg;

    // Operand width of dividend, divisor and quotient.
    localparam int DATA_WIDTH = 32;

    // Iteration counter width: counts DATA_WIDTH - 1 down to zero.
    localparam int CNT_W = $clog2(DATA_WIDTH);

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;

    // Largest positive and most negative quotient values.
    localparam logic [DATA_WIDTH-1:0] INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SIGN
    } state_t;

endpackage : ssdiv_pkg

`default_nettype wire

@@ hw/rtl/shift_subtract_signed_divider_core.sv @@
// ============================================================================
// shift_subtract_signed_divider_core: signed truncating integer divider
// Restoring radix-2 divider on operand magnitudes with a final sign step.
// ============================================================================
// The operand magnitudes are taken with the accepted input transaction. After
// that the shared subtract-and-compare unit works out the quotient bits one
// by one, and then the sign step writes the result to the output register.
// The block holds one division at a time, and s_tready is high only while
// the sequencer is idle, so a new division is taken only once the last one
// has left the sign step. The sign step waits while the output register
// still holds a result that has not been taken. The next transaction is
// taken while a finished result still waits in the output register. A zero
// divisor skips the iterations, returns quotient zero and sets m_tuser. The
// most negative dividend divided by minus one saturates to the largest
// positive value.
`default_nettype none

module shift_subtract_signed_divider_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Bits from low: numerator, denominator
    input  wire logic [ssdiv_pkg::S_TDATA_W-1:0] s_tdata,
    // Result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Bits from low: quotient
    output logic [ssdiv_pkg::M_TDATA_W-1:0]      m_tdata,
    // Bits from low: divide_by_zero
    output logic                                 m_tuser
);

    localparam int DW = ssdiv_pkg::DATA_WIDTH;

    ssdiv_pkg::state_t state_reg, state_next;

    logic [ssdiv_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]               quo_reg, quo_next;
    logic [DW-1:0]               rem_reg, rem_next;
    logic [DW-1:0]               dmag_reg, dmag_next;
    logic                        neg_reg, neg_next;
    logic                        dz_reg, dz_next;

    logic                        m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0]               m_quo_reg, m_quo_next;
    logic                        m_dz_reg, m_dz_next;

    logic [DW-1:0] num_in, den_in, num_mag, den_mag;
    logic [DW:0]   rem_shift, diff;
    logic          fits;
    logic [DW-1:0] result;
    logic          out_free;

    // Operand fields and their magnitudes.
    assign num_in  = s_tdata[DW-1:0];
    assign den_in  = s_tdata[2*DW-1:DW];
    assign num_mag = num_in[DW-1] ? (~num_in + 1'b1) : num_in;
    assign den_mag = den_in[DW-1] ? (~den_in + 1'b1) : den_in;

    // Shared subtract-and-compare unit: one restoring step.
    assign rem_shift = {rem_reg, quo_reg[DW-1]};
    assign diff      = rem_shift - {1'b0, dmag_reg};
    assign fits      = ~diff[DW];

    // Sign step: zero for a zero divisor, negation of a negative quotient, and saturation of the one overflowing case.
    always_comb begin
        if (dz_reg) begin
            result = '0;
        end else if (neg_reg) begin
            result = ~quo_reg + 1'b1;
        end else if (quo_reg[DW-1]) begin
            result = ssdiv_pkg::INT_MAX;
        end else begin
            result = quo_reg;
        end
    end

    assign out_free = ~m_tvalid_reg | m_tready;

    // Next state and datapath control.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dmag_next     = dmag_reg;
        neg_next      = neg_reg;
        dz_next       = dz_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_quo_next    = m_quo_reg;
        m_dz_next     = m_dz_reg;
        s_tready      = 1'b0;

        case (state_reg)
            ssdiv_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    quo_next  = num_mag;
                    rem_next  = '0;
                    dmag_next = den_mag;
                    neg_next  = num_in[DW-1] ^ den_in[DW-1];
                    dz_next   = (den_in == '0);
                    cnt_next  = ssdiv_pkg::CNT_W'(DW - 1);
                    if (den_in == '0) begin
                        state_next = ssdiv_pkg::ST_SIGN;
                    end else begin
                        state_next = ssdiv_pkg::ST_CALC;
                    end
                end
            end
            ssdiv_pkg::ST_CALC: begin
                rem_next = fits ? diff[DW-1:0] : rem_shift[DW-1:0];
                quo_next = {quo_reg[DW-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ssdiv_pkg::ST_SIGN;
                end
            end
            ssdiv_pkg::ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_quo_next    = result;
                    m_dz_next     = dz_reg;
                    state_next    = ssdiv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssdiv_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ssdiv_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dmag_reg  <= dmag_next;
        neg_reg   <= neg_next;
        dz_reg    <= dz_next;
        m_quo_reg <= m_quo_next;
        m_dz_reg  <= m_dz_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ssdiv_pkg::M_TDATA_W'(m_quo_reg);
    assign m_tuser  = m_dz_reg;

    // During the iterations the partial remainder stays below the divisor magnitude.
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssdiv_pkg::ST_CALC) |-> (rem_reg < dmag_reg))
        else $error("partial remainder not below divisor");

    // Iterations never run on a zero divisor.
    a_no_zero_iter: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssdiv_pkg::ST_CALC) |-> (dmag_reg != '0))
        else $error("iteration on zero divisor");

    // A zero-divisor result carries quotient zero.
    a_dz_zero_quo: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("divide-by-zero result with nonzero quotient");

    // A zero divisor goes straight to the sign step.
    a_dz_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tdata[2*DW-1:DW] == '0))
        |=> (state_reg == ssdiv_pkg::ST_SIGN && dz_reg))
        else $error("zero divisor did not skip iterations");

endmodule : shift_subtract_signed_divider_core

`default_nettype wire
